[rtl/jmm_pkg.sv]
// Shared types for the Jones matrix multiply pipeline.
`timescale 1ns / 1ps
`default_nettype none

package jmm_pkg;

  // Signed Q1.15 component.
  typedef logic signed [15:0] q15_t;

  // Packed complex entry: real part in the upper half, imaginary in the lower half.
  typedef struct packed {
    q15_t re;
    q15_t im;
  } cplx_t;

  // Input matrix pair: entries 0..3 are left 11, 12, 21, 22; entries 4..7 are right.
  typedef cplx_t [7:0] mats_t;

  // Result matrix: entries 0..3 are 11, 12, 21, 22.
  typedef cplx_t [3:0] result_t;

  // Exact Q2.30 product of two Q1.15 values.
  typedef logic signed [31:0] prod_t;

  // The eight partial products of one entry a*b + c*d.
  typedef struct packed {
    prod_t ar_br;
    prod_t ai_bi;
    prod_t cr_dr;
    prod_t ci_di;
    prod_t ar_bi;
    prod_t ai_br;
    prod_t cr_di;
    prod_t ci_dr;
  } prods_t;

  typedef prods_t [3:0] prod_set_t;

  // Sum of four Q2.30 products needs two extra bits.
  typedef logic signed [33:0] acc_t;

  typedef struct packed {
    acc_t re;
    acc_t im;
  } acc_cplx_t;

  typedef acc_cplx_t [3:0] acc_set_t;

  // Entry layout inside mats_t.
  localparam int unsigned LeftBase  = 0;
  localparam int unsigned RightBase = 4;

endpackage

`default_nettype wire

[rtl/jmm_capture.sv]
// Input register stage: captures a matrix pair and zeroes imaginary parts in real mode.
`timescale 1ns / 1ps
`default_nettype none

module jmm_capture (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_op,
  input  wire jmm_pkg::mats_t in_mats,
  output logic                out_valid,
  input  wire logic           out_ready,
  output jmm_pkg::mats_t      out_mats
);
  import jmm_pkg::*;

  mats_t mats_next;

  // The stage takes a new item when it is empty or its item moves on.
  assign in_ready = !out_valid || out_ready;

  // Real mode takes every imaginary half as zero.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mats_next[i].re = in_mats[i].re;
      mats_next[i].im = in_op ? '0 : in_mats[i].im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_mats <= mats_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jmm_multiply.sv]
// Product stage: forms the 32 exact Q2.30 partial products of the four result entries.
`timescale 1ns / 1ps
`default_nettype none

module jmm_multiply (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire jmm_pkg::mats_t in_mats,
  output logic                out_valid,
  input  wire logic           out_ready,
  output jmm_pkg::prod_set_t  out_prods
);
  import jmm_pkg::*;

  prod_set_t prods_next;

  // Signed 16 by 16 multiply, exact in 32 bits.
  function automatic prod_t mul(input q15_t x, input q15_t y);
    return prod_t'(x) * prod_t'(y);
  endfunction

  assign in_ready = !out_valid || out_ready;

  // Entry (row, col) is L[row][1]*R[1][col] + L[row][2]*R[2][col].
  always_comb begin
    cplx_t a;
    cplx_t b;
    cplx_t c;
    cplx_t d;
    for (int k = 0; k < 4; k++) begin
      a = in_mats[LeftBase + 2 * (k / 2)];
      c = in_mats[LeftBase + 2 * (k / 2) + 1];
      b = in_mats[RightBase + (k % 2)];
      d = in_mats[RightBase + 2 + (k % 2)];
      prods_next[k].ar_br = mul(a.re, b.re);
      prods_next[k].ai_bi = mul(a.im, b.im);
      prods_next[k].cr_dr = mul(c.re, d.re);
      prods_next[k].ci_di = mul(c.im, d.im);
      prods_next[k].ar_bi = mul(a.re, b.im);
      prods_next[k].ai_br = mul(a.im, b.re);
      prods_next[k].cr_di = mul(c.re, d.im);
      prods_next[k].ci_dr = mul(c.im, d.re);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prods <= prods_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jmm_accum.sv]
// Sum stage: adds the partial products into exact real and imaginary sums.
`timescale 1ns / 1ps
`default_nettype none

module jmm_accum (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jmm_pkg::prod_set_t in_prods,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jmm_pkg::acc_set_t       out_sums
);
  import jmm_pkg::*;

  acc_set_t sums_next;

  // Sign-extend a product to the sum width.
  function automatic acc_t ext(input prod_t p);
    return {{2{p[31]}}, p};
  endfunction

  assign in_ready = !out_valid || out_ready;

  // Real part: ar*br - ai*bi + cr*dr - ci*di; imaginary: ar*bi + ai*br + cr*di + ci*dr.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sums_next[k].re = ext(in_prods[k].ar_br) - ext(in_prods[k].ai_bi)
                      + ext(in_prods[k].cr_dr) - ext(in_prods[k].ci_di);
      sums_next[k].im = ext(in_prods[k].ar_bi) + ext(in_prods[k].ai_br)
                      + ext(in_prods[k].cr_di) + ext(in_prods[k].ci_dr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sums <= sums_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jmm_round.sv]
// Output stage: rounds each sum to Q1.15, saturates it and holds the result for transfer.
`timescale 1ns / 1ps
`default_nettype none

module jmm_round (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire jmm_pkg::acc_set_t in_sums,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jmm_pkg::result_t       out_result,
  output logic                   out_sat
);
  import jmm_pkg::*;

  result_t result_next;
  logic    sat_next;
  logic    sat_re [4];
  logic    sat_im [4];

  // Round to nearest with ties upward, then clip to the Q1.15 range.
  function automatic q15_t round_sat(input acc_t acc, output logic clipped);
    logic signed [34:0] biased;
    logic signed [19:0] rnd;
    biased = {acc[33], acc} + 35'sd16384;
    rnd = biased[34:15];
    clipped = 1'b0;
    if (rnd > 20'sd32767) begin
      clipped = 1'b1;
      return 16'sh7fff;
    end else if (rnd < -20'sd32768) begin
      clipped = 1'b1;
      return 16'sh8000;
    end
    return rnd[15:0];
  endfunction

  assign in_ready = !out_valid || out_ready;

  // In real mode the imaginary sums are zero, so they round to zero and never clip.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      result_next[k].re = round_sat(in_sums[k].re, sat_re[k]);
      result_next[k].im = round_sat(in_sums[k].im, sat_im[k]);
    end
    sat_next = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sat_next = sat_next | sat_re[k] | sat_im[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_result <= result_next;
      out_sat    <= sat_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jones_matrix_multiply_top.sv]
// Each input transfer passes the capture, multiply, sum and round registers, each holding one item,
// before reaching the master side. Throughput: one matrix pair per cycle unless the output stalls.
// A stalled output stops only the stages behind it, and empty stages keep filling.
// Reset: synchronous rst clears every stage valid bit; data registers are not reset.
// Nothing is kept from one item to the next.
`timescale 1ns / 1ps
`default_nettype none

module jones_matrix_multiply_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // Fields from bit 0 up: left_11, left_12, left_21, left_22,
  // right_11, right_12, right_21, right_22 (32 bits each).
  input  wire logic [255:0] s_tdata,
  // Fields from bit 0 up: op.
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // Fields from bit 0 up: out_11, out_12, out_21, out_22 (32 bits each).
  output logic [127:0]      m_tdata,
  // Fields from bit 0 up: saturated.
  output logic [0:0]        m_tuser
);
  import jmm_pkg::*;

  logic      cap_valid;
  logic      cap_ready;
  mats_t     cap_mats;
  logic      mul_valid;
  logic      mul_ready;
  prod_set_t mul_prods;
  logic      acc_valid;
  logic      acc_ready;
  acc_set_t  acc_sums;
  result_t   result;
  logic      sat;

  // Stage one: input capture.
  jmm_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_mats   (mats_t'(s_tdata)),
    .out_valid (cap_valid),
    .out_ready (cap_ready),
    .out_mats  (cap_mats)
  );

  // Stage two: partial products.
  jmm_multiply u_multiply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cap_valid),
    .in_ready  (cap_ready),
    .in_mats   (cap_mats),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_prods (mul_prods)
  );

  // Stage three: exact sums.
  jmm_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_prods  (mul_prods),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .out_sums  (acc_sums)
  );

  // Stage four: rounding, saturation and the output register.
  jmm_round u_round (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (acc_valid),
    .in_ready   (acc_ready),
    .in_sums    (acc_sums),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result),
    .out_sat    (sat)
  );

  assign m_tdata    = result;
  assign m_tuser[0] = sat;

  // An empty output register means no stage can be blocked, so the input side is open.
  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready while the output stage is empty");

  // A saturated result must carry at least one component at a range limit.
  a_sat_has_limit : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sat) |->
      (result[0].re == 16'h7fff || result[0].re == 16'h8000 ||
       result[0].im == 16'h7fff || result[0].im == 16'h8000 ||
       result[1].re == 16'h7fff || result[1].re == 16'h8000 ||
       result[1].im == 16'h7fff || result[1].im == 16'h8000 ||
       result[2].re == 16'h7fff || result[2].re == 16'h8000 ||
       result[2].im == 16'h7fff || result[2].im == 16'h8000 ||
       result[3].re == 16'h7fff || result[3].re == 16'h8000 ||
       result[3].im == 16'h7fff || result[3].im == 16'h8000))
    else $error("saturation flag set with no clipped component");

  // Reset empties the pipeline.
  a_reset_empties : assert property (@(posedge clk)
    rst |=> (!m_tvalid && !cap_valid && !mul_valid && !acc_valid))
    else $error("pipeline not empty after reset");

  // A result only appears in the cycle after the sum stage held an item.
  a_out_from_sum : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(acc_valid))
    else $error("result appeared without a summed item behind it");

endmodule

`default_nettype wire

[bench/jones_matrix_multiply_top_tb.sv]
// Stream testbench for the Jones matrix multiply, checking every product against a predictor.
`timescale 1ns / 1ps

module jones_matrix_multiply_top_tb;
  import jmm_pkg::*;

  localparam logic        OpComplex  = 1'b0;
  localparam logic        OpRealOnly = 1'b1;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned MaxReports = 10;

  // Shapes of random operand values.
  typedef enum int unsigned {
    PatAny,
    PatExtreme,
    PatSmall,
    PatNearFull
  } operand_pattern_e;

  // One expected product: four entries and the clip flag.
  typedef struct packed {
    logic    clipped;
    result_t entries;
  } product_t;

  // Predicts each product and compares transfers on the master side in order.
  class product_scoreboard;
    product_t    pending_products[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Round a Q2.30 sum to nearest (ties up) and clip to Q1.15.
    function q15_t round_clip(longint acc, inout logic clipped);
      longint r;
      r = (acc + 64'sd16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
        clipped = 1'b1;
      end else if (r < -32768) begin
        r = -32768;
        clipped = 1'b1;
      end
      return q15_t'(r);
    endfunction

    // One product entry a*b + c*d, summed exactly before rounding.
    function cplx_t sum_of_products(cplx_t a, cplx_t b, cplx_t c, cplx_t d,
                                    logic real_only, inout logic clipped);
      longint ar, ai, br, bi, cr, ci, dr, di;
      longint re_sum, im_sum;
      cplx_t  res;
      ar = a.re;
      br = b.re;
      cr = c.re;
      dr = d.re;
      ai = 0;
      bi = 0;
      ci = 0;
      di = 0;
      if (!real_only) begin
        ai = a.im;
        bi = b.im;
        ci = c.im;
        di = d.im;
      end
      re_sum = ar * br - ai * bi + cr * dr - ci * di;
      im_sum = ar * bi + ai * br + cr * di + ci * dr;
      res.re = round_clip(re_sum, clipped);
      res.im = '0;
      // In real mode the imaginary half is forced to zero and cannot clip.
      if (!real_only) begin
        res.im = round_clip(im_sum, clipped);
      end
      return res;
    endfunction

    function product_t predict(logic real_only, mats_t m);
      product_t p;
      logic     clipped;
      clipped = 1'b0;
      for (int row = 0; row < 2; row++) begin
        for (int col = 0; col < 2; col++) begin
          p.entries[row * 2 + col] = sum_of_products(
            m[LeftBase + row * 2], m[RightBase + col],
            m[LeftBase + row * 2 + 1], m[RightBase + 2 + col], real_only, clipped);
        end
      end
      p.clipped = clipped;
      return p;
    endfunction

    // Called for every accepted input transfer.
    function void note_pair(logic op, mats_t m);
      pending_products.push_back(predict(op == OpRealOnly, m));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
    endfunction

    // Called for every accepted output transfer.
    function void check_product(result_t got, logic got_clipped);
      product_t want;
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result: %h saturated %b", got, got_clipped);
        end
        return;
      end
      want = pending_products.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want.entries[i]) begin
          report($sformatf("out_%0d%0d", i / 2 + 1, i % 2 + 1), want.entries[i], got[i]);
        end
      end
      if (got_clipped !== want.clipped) begin
        report("saturated", 32'(want.clipped), 32'(got_clipped));
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [0:0]   m_tuser;

  product_scoreboard products = new();
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  logic              hold_go = 1'b0;
  logic              long_hold = 1'b0;
  int unsigned       cycle_count = 0;

  jones_matrix_multiply_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Run limit in case the pipeline hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every output transfer.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      products.check_product(result_t'(m_tdata), m_tuser[0]);
    end
  end

  // One long hold-off of the receiver, counted here, once the stimulus asks for it.
  initial begin
    while (!hold_go) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Receiver: random stalls at the current rate.
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one matrix pair and hold it until the block takes it.
  task automatic send_pair(input logic op, input mats_t m);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= m;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    products.note_pair(op, m);
    @(negedge clk);
  endtask

  // Stop sending until every expected product has come back.
  task automatic drain_products();
    s_tvalid <= 1'b0;
    while (products.pending_products.size() != 0) @(negedge clk);
  endtask

  function automatic mats_t uniform_pair(logic [31:0] left, logic [31:0] right);
    mats_t m;
    for (int i = 0; i < 4; i++) begin
      m[LeftBase + i]  = left;
      m[RightBase + i] = right;
    end
    return m;
  endfunction

  // Only left_11 and right_11 set, so one product reaches out_11.
  function automatic mats_t single_pair(logic [31:0] left_11, logic [31:0] right_11);
    mats_t m;
    m = '0;
    m[LeftBase]  = left_11;
    m[RightBase] = right_11;
    return m;
  endfunction

  function automatic q15_t pick_component(operand_pattern_e pattern);
    int magnitude;
    case (pattern)
      PatAny: begin
        return q15_t'($urandom);
      end
      PatExtreme: begin
        case ($urandom_range(4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      PatSmall: begin
        return q15_t'(int'($urandom_range(2047)) - 1024);
      end
      default: begin
        // Large magnitudes put the sums near the clip limits.
        magnitude = int'($urandom_range(32767, 16384));
        return q15_t'($urandom_range(1) ? -magnitude : magnitude);
      end
    endcase
  endfunction

  function automatic mats_t random_pair();
    mats_t            m;
    operand_pattern_e pattern;
    pattern = operand_pattern_e'($urandom_range(3));
    for (int i = 0; i < 8; i++) begin
      m[i].re = pick_component(pattern);
      m[i].im = pick_component(pattern);
    end
    return m;
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned idle,
                           input int unsigned stall, input bit with_hold);
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 20) begin
        hold_go <= 1'b1;
      end
      send_pair($urandom_range(1) ? OpRealOnly : OpComplex, random_pair());
    end
    drain_products();
  endtask

  // Main stimulus.
  initial begin
    mats_t diag;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed cases: extremes, both modes, rounding ties and clipping.
    idle_pct  = 30;
    stall_pct = 30;
    send_pair(OpComplex, uniform_pair(32'h0000_0000, 32'h0000_0000));
    send_pair(OpComplex, uniform_pair(32'h7FFF_7FFF, 32'h7FFF_7FFF));
    send_pair(OpRealOnly, uniform_pair(32'h7FFF_7FFF, 32'h7FFF_7FFF));
    send_pair(OpComplex, uniform_pair(32'h8000_8000, 32'h8000_8000));
    send_pair(OpRealOnly, uniform_pair(32'h8000_8000, 32'h8000_8000));
    send_pair(OpComplex, uniform_pair(32'h7FFF_7FFF, 32'h8000_8000));
    send_pair(OpRealOnly, uniform_pair(32'h7FFF_0000, 32'h8000_0000));
    send_pair(OpComplex, uniform_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_pair(OpRealOnly, uniform_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_pair(OpComplex, uniform_pair(32'hAAAA_AAAA, 32'h5555_5555));
    send_pair(OpRealOnly, uniform_pair(32'hAAAA_AAAA, 32'h5555_5555));
    send_pair(OpComplex, uniform_pair(32'h5555_5555, 32'hAAAA_AAAA));
    // Half-LSB ties round upward, on both halves and both signs.
    send_pair(OpComplex, single_pair(32'h0001_0000, 32'h4000_0000));
    send_pair(OpComplex, single_pair(32'h0000_0001, 32'h4000_0000));
    send_pair(OpComplex, single_pair(32'hFFFF_0000, 32'h4000_0000));
    // A single full-scale negative squared clips to the top.
    send_pair(OpRealOnly, single_pair(32'h8000_0000, 32'h8000_0000));
    // Imaginary halves that would clip must be ignored in real mode.
    send_pair(OpRealOnly, uniform_pair(32'h4000_7FFF, 32'h4000_7FFF));
    send_pair(OpComplex, uniform_pair(32'h4000_7FFF, 32'h4000_7FFF));
    // Near-identity on the left passes the right matrix through.
    diag = random_pair();
    diag[LeftBase]     = 32'h7FFF_0000;
    diag[LeftBase + 1] = 32'h0000_0000;
    diag[LeftBase + 2] = 32'h0000_0000;
    diag[LeftBase + 3] = 32'h7FFF_0000;
    send_pair(OpComplex, diag);
    for (int n = 0; n < 3; n++) begin
      send_pair(OpComplex, random_pair());
    end
    drain_products();

    // Random traffic under each handshake pattern.
    run_phase(250, 0, 0, 1'b1);
    run_phase(250, 78, 0, 1'b0);
    run_phase(250, 0, 78, 1'b0);
    run_phase(250, 19, 19, 1'b0);

    // Let any stray output show up before the verdict.
    repeat (10) @(posedge clk);
    if (products.mismatches == 0 && products.pending_products.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
